### rtl/apgs_pkg.sv
// ----------------------------------------------------------------------------
// apgs_pkg - shared types and constants of the probability gradient step
// Fixed-point widths, register indexes, configuration and multiplier words.
// ----------------------------------------------------------------------------
package apgs_pkg;

	// Q1.F probability format
	localparam int FRAC_BITS = 16;
	localparam int PROB_W    = FRAC_BITS + 1;
	localparam logic [PROB_W-1:0] ONE      = PROB_W'(1) << FRAC_BITS;
	localparam logic [PROB_W-1:0] PROB_MAX = '1;

	// field and register widths
	localparam int WIN_W = 8;
	localparam int GS_W  = 20;
	localparam int WT_W  = 16;
	localparam int WE_W  = 16;

	// gradient saturates at +-2^GRAD_LIM_SH, held in G_W signed bits
	localparam int GRAD_LIM_SH = 40;
	localparam int G_W         = GRAD_LIM_SH + 2;

	// shared multiplier: chunk of operand A times operand B
	localparam int CW = 18;
	localparam int BW = 20;

	// divider for the single-user term: (|1 - p| << F) / q
	localparam int DIVD_W = PROB_W + FRAC_BITS;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 20;

	localparam logic [CFG_IDX_W-1:0] CFG_GRADIENT_STEP     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_THROUGHPUT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_ENERGY     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_EPSILON           = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_PROB          = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_PROB          = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_STEP          = 3'd6;

	typedef struct packed {
		logic [GS_W-1:0]   gradient_step;
		logic [WT_W-1:0]   weight_throughput;
		logic [WE_W-1:0]   weight_energy;
		logic [PROB_W-1:0] epsilon;
		logic [PROB_W-1:0] min_prob;
		logic [PROB_W-1:0] max_prob;
		logic [PROB_W-1:0] max_step;
	} cfg_t;

	// one multiply-accumulate request; first clears the sum and signs the chunk
	typedef struct packed {
		logic          en;
		logic          first;
		logic [CW-1:0] chunk;
		logic [BW-1:0] b;
	} mac_req_t;

endpackage

### rtl/apgs_cfg.sv
// ----------------------------------------------------------------------------
// apgs_cfg - configuration registers
// Plain write port; unknown indexes are dropped.
// ----------------------------------------------------------------------------
module apgs_cfg import apgs_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_write,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                  cfg
);

	localparam logic [GS_W-1:0]   RST_GS  = GS_W'(1049);
	localparam logic [WT_W-1:0]   RST_WT  = WT_W'(256);
	localparam logic [WE_W-1:0]   RST_WE  = WE_W'(26);
	localparam logic [PROB_W-1:0] RST_EPS = PROB_W'(66);
	localparam logic [PROB_W-1:0] RST_MIN = PROB_W'(655);
	localparam logic [PROB_W-1:0] RST_MAX = PROB_W'(65536);
	localparam logic [PROB_W-1:0] RST_MS  = PROB_W'(3277);

	cfg_t cfg_q;

	// write one register per word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gradient_step     <= RST_GS;
			cfg_q.weight_throughput <= RST_WT;
			cfg_q.weight_energy     <= RST_WE;
			cfg_q.epsilon           <= RST_EPS;
			cfg_q.min_prob          <= RST_MIN;
			cfg_q.max_prob          <= RST_MAX;
			cfg_q.max_step          <= RST_MS;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_GRADIENT_STEP:     cfg_q.gradient_step     <= cfg_data[GS_W-1:0];
				CFG_WEIGHT_THROUGHPUT: cfg_q.weight_throughput <= cfg_data[WT_W-1:0];
				CFG_WEIGHT_ENERGY:     cfg_q.weight_energy     <= cfg_data[WE_W-1:0];
				CFG_EPSILON:           cfg_q.epsilon           <= cfg_data[PROB_W-1:0];
				CFG_MIN_PROB:          cfg_q.min_prob          <= cfg_data[PROB_W-1:0];
				CFG_MAX_PROB:          cfg_q.max_prob          <= cfg_data[PROB_W-1:0];
				CFG_MAX_STEP:          cfg_q.max_step          <= cfg_data[PROB_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### rtl/apgs_mac.sv
// ----------------------------------------------------------------------------
// apgs_mac - shared multiply-accumulate unit
// One CW-bit chunk of a wide operand times a BW-bit unsigned operand per
// cycle, accumulated MSB chunk first: sum = (sum << CW) + chunk * b.
// ----------------------------------------------------------------------------
module apgs_mac import apgs_pkg::*; #(
	parameter int ACC_W = 71
) (
	input  logic                    clk,
	input  mac_req_t                req,
	output logic signed [ACC_W-1:0] acc
);

	logic signed [CW:0]         a_s;
	logic signed [BW:0]         b_s;
	logic signed [CW+BW+1:0]    prod;
	logic signed [ACC_W-1:0]    base;
	logic signed [ACC_W-1:0]    acc_q;

	// top chunk carries the sign, lower chunks are unsigned
	assign a_s  = {req.first & req.chunk[CW-1], req.chunk};
	assign b_s  = {1'b0, req.b};
	assign prod = a_s * b_s;
	assign base = req.first ? '0 : (acc_q <<< CW);

	// advance the sum
	always_ff @(posedge clk) begin
		if (req.en) begin
			acc_q <= base + ACC_W'(prod);
		end
	end

	assign acc = acc_q;

endmodule

### rtl/apgs_div.sv
// ----------------------------------------------------------------------------
// apgs_div - radix-2 restoring divider
// Unsigned DIVD_W / PROB_W bits, one quotient bit per cycle; done pulses
// for one cycle when the quotient is ready.
// ----------------------------------------------------------------------------
module apgs_div import apgs_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DIVD_W-1:0] dividend,
	input  logic [PROB_W-1:0] divisor,
	output logic              done,
	output logic [DIVD_W-1:0] quotient
);

	localparam int CNT_W = $clog2(DIVD_W + 1);

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [DIVD_W-1:0] work_q;
	logic [PROB_W-1:0] rem_q;
	logic [PROB_W-1:0] dsr_q;
	logic [PROB_W:0]   rem_sh;
	logic [PROB_W:0]   rem_sub;
	logic              ge;

	// shift in the next dividend bit and try a subtract
	assign rem_sh  = {rem_q, work_q[DIVD_W-1]};
	assign ge      = rem_sh >= {1'b0, dsr_q};
	assign rem_sub = rem_sh - {1'b0, dsr_q};

	// control: count the steps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CNT_W'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DIVD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// datapath: quotient bits replace dividend bits
	always_ff @(posedge clk) begin
		if (start) begin
			work_q <= dividend;
			rem_q  <= '0;
			dsr_q  <= divisor;
		end else if (busy_q) begin
			work_q <= {work_q[DIVD_W-2:0], ge};
			rem_q  <= ge ? rem_sub[PROB_W-1:0] : rem_sh[PROB_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = work_q;

endmodule

### rtl/access_probability_gradient_step_unit.sv
// ----------------------------------------------------------------------------
// access_probability_gradient_step_unit - p-persistent access gradient step
// One gradient step on the transmit probability: clamp p, q = max(eps, 1-p),
// gradient wT*n*q^(n-2)*(1-n*p) - wE*n, step clamped to +-max_step, new p
// clamped to [min_prob, max_prob]; the window passes through.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+-------------------------------
//   cfg     | in        | cfg_write             | cfg_index, cfg_data
//   in      | in        | in_valid / in_ready   | current_prob, current_window,
//           |           |                       | ready_users
//   out     | out       | out_valid / out_ready | next_prob, next_window
//
// One word at a time: in_ready is high only while the sequencer is idle.
// With two or more users the time from taking a word to out_valid is set by
// the square-and-multiply loop on the shared multiplier; with zero or one
// user it is set by the 33-step divider. The sequencer passes through its
// idle state before the next word is taken.
// The result sits in an output register, so the next word is taken while it
// waits; a full output register holds the last step.
// Reset clears the sequencer, the divider control and out_valid.
// ----------------------------------------------------------------------------
module access_probability_gradient_step_unit import apgs_pkg::*; #(
	parameter int USER_BITS = 10
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_write,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [PROB_W-1:0]     current_prob,
	input  logic [WIN_W-1:0]      current_window,
	input  logic [USER_BITS-1:0]  ready_users,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [PROB_W-1:0]     next_prob,
	output logic [WIN_W-1:0]      next_window
);

	// operand widths that follow from the user count
	localparam int LIN_W  = USER_BITS + PROB_W + 1;
	localparam int T_W    = USER_BITS + PROB_W + 2;
	localparam int DSN_W  = 2 * USER_BITS + PROB_W + 2;
	localparam int DS_W   = (DSN_W > DIVD_W + 1) ? DSN_W : DIVD_W + 1;
	localparam int MAXA_W = (DS_W > G_W) ? DS_W : G_W;
	localparam int NCH    = (MAXA_W + CW - 1) / CW;
	localparam int OPA_W  = NCH * CW;
	localparam int ACC0_W = (DS_W + WT_W > G_W + GS_W) ? DS_W + WT_W : G_W + GS_W;
	localparam int ACC_W  = ((ACC0_W > OPA_W + FRAC_BITS) ? ACC0_W : OPA_W + FRAC_BITS) + 1;
	localparam int EN_W   = USER_BITS + WE_W;
	localparam int DL_W   = ACC_W - GS_W;
	localparam int PW_W   = ACC_W - FRAC_BITS;
	localparam int K_LIN  = (LIN_W + CW - 1) / CW;
	localparam int K_T    = (T_W + CW - 1) / CW;
	localparam int K_DS   = (DS_W + CW - 1) / CW;
	localparam int K_G    = (G_W + CW - 1) / CW;
	localparam int CI_W   = $clog2(NCH);
	localparam int BIT_W  = $clog2(USER_BITS);

	localparam logic signed [ACC_W:0] GLIM = (ACC_W+1)'(1) <<< GRAD_LIM_SH;

	// sequencer states
	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_SETUP = 4'd1;
	localparam logic [3:0] S_EN    = 4'd2;
	localparam logic [3:0] S_LIN   = 4'd3;
	localparam logic [3:0] S_PSQ   = 4'd4;
	localparam logic [3:0] S_PMUL  = 4'd5;
	localparam logic [3:0] S_M1LD  = 4'd6;
	localparam logic [3:0] S_M1    = 4'd7;
	localparam logic [3:0] S_TLD   = 4'd8;
	localparam logic [3:0] S_T     = 4'd9;
	localparam logic [3:0] S_DIV   = 4'd10;
	localparam logic [3:0] S_DSLD  = 4'd11;
	localparam logic [3:0] S_DS    = 4'd12;
	localparam logic [3:0] S_GRAD  = 4'd13;
	localparam logic [3:0] S_DL    = 4'd14;
	localparam logic [3:0] S_FIN   = 4'd15;

	cfg_t                    cfg;
	mac_req_t                mreq;
	logic signed [ACC_W-1:0] acc;

	logic [3:0]              state_q;
	logic [PROB_W-1:0]       cur_q;
	logic [WIN_W-1:0]        win_q;
	logic [USER_BITS-1:0]    n_q;
	logic [USER_BITS-1:0]    k_q;
	logic                    n_one_q;
	logic [PROB_W-1:0]       p_q;
	logic [PROB_W-1:0]       q_q;
	logic [EN_W-1:0]         en_q;
	logic [OPA_W-1:0]        opa_q;
	logic [BW-1:0]           opb_q;
	logic [CI_W-1:0]         ci_q;
	logic [BIT_W-1:0]        bit_q;
	logic                    neg_q;
	logic                    out_valid_q;
	logic [PROB_W-1:0]       next_prob_q;
	logic [WIN_W-1:0]        next_window_q;

	logic                    accept;
	logic                    out_free;
	logic [PROB_W-1:0]       p_in;
	logic signed [PROB_W:0]  q_diff;
	logic [PROB_W-1:0]       q_eps;
	logic [PROB_W-1:0]       q_new;
	logic [PW_W-1:0]         pw_sh;
	logic [PROB_W-1:0]       pw_src;
	logic [CW-1:0]           opa_chunk;
	logic signed [ACC_W-1:0] lin_full;
	logic                    div_start;
	logic                    div_done;
	logic [DIVD_W-1:0]       div_quot;
	logic [PROB_W-1:0]       div_mag;
	logic signed [DIVD_W:0]  ds_div;
	logic signed [ACC_W:0]   g0;
	logic signed [ACC_W:0]   g1;
	logic signed [ACC_W:0]   gsat;
	logic signed [DL_W-1:0]  dl;
	logic signed [DL_W-1:0]  ms_s;
	logic signed [PROB_W:0]  dclamp;
	logic signed [PROB_W+1:0] sum_p;
	logic [PROB_W-1:0]       res;

	// clamp a signed value to [lo, hi]; crossed limits give lo
	function automatic logic [PROB_W-1:0] clamp_prob(
		input logic signed [PROB_W+1:0] v,
		input logic [PROB_W-1:0]        lo,
		input logic [PROB_W-1:0]        hi
	);
		logic signed [PROB_W+1:0] t;
		t = (v < $signed({2'b00, hi})) ? v : $signed({2'b00, hi});
		t = (t > $signed({2'b00, lo})) ? t : $signed({2'b00, lo});
		return t[PROB_W-1:0];
	endfunction

	apgs_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	apgs_mac #(.ACC_W(ACC_W)) u_mac (
		.clk (clk),
		.req (mreq),
		.acc (acc)
	);

	apgs_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend ({div_mag, {FRAC_BITS{1'b0}}}),
		.divisor  (q_q),
		.done     (div_done),
		.quotient (div_quot)
	);

	assign accept   = (state_q == S_IDLE) && in_valid;
	assign out_free = !out_valid_q || out_ready;

	// clamp p on entry, then q = max(max(eps, 1 - p), 1 LSB)
	assign p_in   = clamp_prob($signed({2'b00, current_prob}), cfg.min_prob, cfg.max_prob);
	assign q_diff = $signed({1'b0, ONE}) - $signed({1'b0, p_q});
	assign q_eps  = (q_diff < $signed({1'b0, cfg.epsilon})) ? cfg.epsilon : q_diff[PROB_W-1:0];
	assign q_new  = (q_eps == '0) ? PROB_W'(1) : q_eps;

	// truncate the last product to Q1.F and saturate
	assign pw_sh  = acc[ACC_W-1:FRAC_BITS];
	assign pw_src = (pw_sh > PW_W'(PROB_MAX)) ? PROB_MAX : pw_sh[PROB_W-1:0];

	assign opa_chunk = opa_q[int'(ci_q)*CW +: CW];
	assign lin_full  = $signed(ACC_W'(ONE)) - acc;

	// single-user term: sign and magnitude of 1 - p
	assign div_start = (state_q == S_EN) && n_one_q;
	assign div_mag   = (p_q > ONE) ? (p_q - ONE) : (ONE - p_q);
	assign ds_div    = neg_q ? -$signed({1'b0, div_quot}) : $signed({1'b0, div_quot});

	// gradient: floor to Q.F and saturate
	assign g0   = (ACC_W+1)'(acc) - $signed((ACC_W+1)'({en_q, {FRAC_BITS{1'b0}}}));
	assign g1   = g0 >>> 8;
	assign gsat = (g1 > GLIM) ? GLIM : ((g1 < -GLIM) ? -GLIM : g1);

	// step: floor, clamp to +-max_step, add and clamp
	assign dl     = acc[ACC_W-1:GS_W];
	assign ms_s   = $signed(DL_W'(cfg.max_step));
	assign dclamp = (dl > ms_s) ? ms_s[PROB_W:0] : ((dl < -ms_s) ? -ms_s[PROB_W:0] : dl[PROB_W:0]);
	assign sum_p  = $signed({2'b00, cur_q}) + (PROB_W+2)'(dclamp);
	assign res    = clamp_prob(sum_p, cfg.min_prob, cfg.max_prob);

	// drive the shared multiplier
	always_comb begin
		mreq = '{en: 1'b0, first: 1'b1, chunk: '0, b: '0};
		case (state_q)
			S_SETUP: begin
				mreq = '{en: 1'b1, first: 1'b1, chunk: CW'(n_q), b: BW'(cfg.weight_energy)};
			end
			S_EN: begin
				mreq = '{en: !n_one_q, first: 1'b1, chunk: CW'(p_q), b: BW'(n_q)};
			end
			S_LIN: begin
				mreq = '{en: 1'b1, first: 1'b1, chunk: CW'(ONE), b: BW'(ONE)};
			end
			S_PSQ: begin
				mreq = '{en: 1'b1, first: 1'b1, chunk: CW'(pw_src), b: BW'(pw_src)};
			end
			S_PMUL: begin
				mreq = '{en: 1'b1, first: 1'b1, chunk: CW'(pw_src), b: BW'(q_q)};
			end
			S_M1: begin
				mreq = '{en: 1'b1, first: (ci_q == CI_W'(K_LIN - 1)), chunk: opa_chunk, b: opb_q};
			end
			S_T: begin
				mreq = '{en: 1'b1, first: (ci_q == CI_W'(K_T - 1)), chunk: opa_chunk, b: opb_q};
			end
			S_DS: begin
				mreq = '{en: 1'b1, first: (ci_q == CI_W'(K_DS - 1)), chunk: opa_chunk, b: opb_q};
			end
			S_DL: begin
				mreq = '{en: 1'b1, first: (ci_q == CI_W'(K_G - 1)), chunk: opa_chunk, b: opb_q};
			end
			default: begin
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			// load a finished step or drop a delivered one
			if ((state_q == S_FIN) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE:  if (accept) state_q <= S_SETUP;
				S_SETUP: state_q <= S_EN;
				S_EN:    state_q <= n_one_q ? S_DIV : S_LIN;
				S_LIN:   state_q <= S_PSQ;
				S_PSQ: begin
					if (k_q[bit_q]) begin
						state_q <= S_PMUL;
					end else if (bit_q == '0) begin
						state_q <= S_M1LD;
					end
				end
				S_PMUL:  state_q <= (bit_q == '0) ? S_M1LD : S_PSQ;
				S_M1LD:  state_q <= S_M1;
				S_M1:    if (ci_q == '0) state_q <= S_TLD;
				S_TLD:   state_q <= S_T;
				S_T:     if (ci_q == '0) state_q <= S_DSLD;
				S_DIV:   if (div_done) state_q <= S_DSLD;
				S_DSLD:  state_q <= S_DS;
				S_DS:    if (ci_q == '0) state_q <= S_GRAD;
				S_GRAD:  state_q <= S_DL;
				S_DL:    if (ci_q == '0) state_q <= S_FIN;
				S_FIN: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					cur_q   <= current_prob;
					win_q   <= current_window;
					n_q     <= (ready_users == '0) ? USER_BITS'(1) : ready_users;
					n_one_q <= (ready_users <= USER_BITS'(1));
					p_q     <= p_in;
				end
			end
			S_SETUP: begin
				q_q <= q_new;
				k_q <= n_q - USER_BITS'(2);
			end
			S_EN: begin
				en_q  <= acc[EN_W-1:0];
				neg_q <= p_q > ONE;
			end
			S_LIN: begin
				opa_q <= lin_full[OPA_W-1:0];
				bit_q <= BIT_W'(USER_BITS - 1);
			end
			S_PSQ: begin
				if (!k_q[bit_q]) begin
					bit_q <= bit_q - BIT_W'(1);
				end
			end
			S_PMUL: begin
				bit_q <= bit_q - BIT_W'(1);
			end
			S_M1LD: begin
				opb_q <= BW'(pw_src);
				ci_q  <= CI_W'(K_LIN - 1);
			end
			S_TLD: begin
				opa_q <= acc[OPA_W+FRAC_BITS-1:FRAC_BITS];
				opb_q <= BW'(n_q);
				ci_q  <= CI_W'(K_T - 1);
			end
			S_DSLD: begin
				opa_q <= n_one_q ? OPA_W'(ds_div) : acc[OPA_W-1:0];
				opb_q <= BW'(cfg.weight_throughput);
				ci_q  <= CI_W'(K_DS - 1);
			end
			S_GRAD: begin
				opa_q <= gsat[OPA_W-1:0];
				opb_q <= BW'(cfg.gradient_step);
				ci_q  <= CI_W'(K_G - 1);
			end
			S_M1, S_T, S_DS, S_DL: begin
				ci_q <= ci_q - CI_W'(1);
			end
			S_FIN: begin
				if (out_free) begin
					next_prob_q   <= res;
					next_window_q <= win_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign in_ready    = (state_q == S_IDLE);
	assign out_valid   = out_valid_q;
	assign next_prob   = next_prob_q;
	assign next_window = next_window_q;

endmodule

### rtl/apgs_checker.sv
// ----------------------------------------------------------------------------
// apgs_checker - port-level checks for the gradient step unit
// Tracks words in flight and checks handshake order and hold.
// ----------------------------------------------------------------------------
module apgs_checker import apgs_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic              out_valid,
	input logic              out_ready,
	input logic [PROB_W-1:0] next_prob,
	input logic [WIN_W-1:0]  next_window
);

	logic       in_acc;
	logic       out_acc;
	logic [1:0] pending_q;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	// count words taken but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= 2'd0;
		end else if (in_acc && !out_acc) begin
			pending_q <= pending_q + 2'd1;
		end else if (out_acc && !in_acc) begin
			pending_q <= pending_q - 2'd1;
		end
	end

	// one word in work: ready drops after a word is taken
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !in_ready)
		else $error("in_ready high right after an accepted word");

	// at most one word in work plus one waiting in the output register
	a_pending_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q != 2'd3)
		else $error("more words in flight than the block can hold");

	// no result without a word behind it
	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pending_q != 2'd0)
		else $error("result shown with no word in flight");

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(next_prob) && $stable(next_window))
		else $error("stalled result changed or dropped");

endmodule

bind access_probability_gradient_step_unit apgs_checker u_apgs_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.next_prob   (next_prob),
	.next_window (next_window)
);
